/* hdl/vfns_pkg.sv */
`default_nettype none

package vfns_pkg;

    localparam int DIM_BITS = 13;
    localparam int FPS_BITS = 8;

    // area of one format and the widest target area (1280x720 needs 20 bits)
    localparam int AREA_W     = 2 * DIM_BITS;
    localparam int TGT_AREA_W = 20;
    localparam int DIFF_W     = (AREA_W > TGT_AREA_W) ? AREA_W : TGT_AREA_W;

    // fps difference times 10000 (10000 < 2**14)
    localparam int FPS_WEIGHT = 10000;
    localparam int FTERM_W    = FPS_BITS + 14;
    localparam int SCORE_W    = ((DIFF_W > FTERM_W) ? DIFF_W : FTERM_W) + 1;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // nearest-search targets
    localparam int NTGT    = 3;
    localparam int TGT_REQ = 0;
    localparam int TGT_HD  = 1;
    localparam int TGT_SD  = 2;

    localparam int HD_W    = 1280;
    localparam int HD_H    = 720;
    localparam int SD_W    = 640;
    localparam int SD_H    = 480;
    localparam int STD_FPS = 30;

    // acceptance thresholds of the standard-mode chain
    localparam int HD_MIN_W = 960;
    localparam int HD_MIN_H = 540;
    localparam int SD_MIN_W = 480;
    localparam int SD_MIN_H = 360;

    typedef enum logic [1:0] {
        REG_MODE    = 2'd0,
        REG_REQ_W   = 2'd1,
        REG_REQ_H   = 2'd2,
        REG_REQ_FPS = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        SRC_ECHO = 3'd0,
        SRC_REQ  = 3'd1,
        SRC_HD   = 3'd2,
        SRC_SD   = 3'd3,
        SRC_MAX  = 3'd4
    } sel_src_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
        logic [FPS_BITS-1:0] fps;
    } fmt_t;

    typedef struct packed {
        logic              mode;
        fmt_t              req;
        logic [AREA_W-1:0] req_area;
    } cfg_t;

    typedef struct packed {
        logic                          has_entry;
        logic                          is_last;
        fmt_t                          fmt;
        logic [AREA_W-1:0]             area;
        logic [NTGT-1:0][FTERM_W-1:0]  fterm;
    } item_t;

    typedef struct packed {
        fmt_t     fmt;
        sel_src_t by;
    } res_t;

    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic [DIFF_W-1:0] a,
        input logic [DIFF_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [FTERM_W-1:0] fps_term(
        input logic [FPS_BITS-1:0] fps,
        input logic [FPS_BITS-1:0] tgt
    );
        logic [FPS_BITS-1:0] d;
        d = (fps > tgt) ? (fps - tgt) : (tgt - fps);
        return FTERM_W'(d) * FTERM_W'(FPS_WEIGHT);
    endfunction

endpackage

`default_nettype wire

/* hdl/vfns_in_if.sv */
`default_nettype none

interface vfns_in_if
    import vfns_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [DIM_BITS-1:0] cap_width;
    logic [DIM_BITS-1:0] cap_height;
    logic [FPS_BITS-1:0] cap_fps;
    logic                has_entry;
    logic                is_last;

    modport source (
        output valid, cap_width, cap_height, cap_fps, has_entry, is_last,
        input  ready
    );

    modport sink (
        input  valid, cap_width, cap_height, cap_fps, has_entry, is_last,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/vfns_out_if.sv */
`default_nettype none

interface vfns_out_if
    import vfns_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [DIM_BITS-1:0] sel_width;
    logic [DIM_BITS-1:0] sel_height;
    logic [FPS_BITS-1:0] sel_fps;
    logic [2:0]          chosen_by;

    modport source (
        output valid, sel_width, sel_height, sel_fps, chosen_by,
        input  ready
    );

    modport sink (
        input  valid, sel_width, sel_height, sel_fps, chosen_by,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/vfns_cfg.sv */
`default_nettype none

module vfns_cfg
    import vfns_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [PADDR_W-1:0]   paddr,
    input  wire [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    output cfg_t                cfg
);

    logic                mode_reg;
    logic [DIM_BITS-1:0] req_w_reg;
    logic [DIM_BITS-1:0] req_h_reg;
    logic [FPS_BITS-1:0] req_fps_reg;
    logic [AREA_W-1:0]   req_area_reg;
    logic [AREA_W-1:0]   req_area_next;
    logic [DIM_BITS-1:0] w_op;
    logic [DIM_BITS-1:0] h_op;
    reg_idx_t            idx;
    logic                wr;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    // request area follows the register written in the same edge
    assign w_op = (wr && idx == REG_REQ_W) ? pwdata[DIM_BITS-1:0] : req_w_reg;
    assign h_op = (wr && idx == REG_REQ_H) ? pwdata[DIM_BITS-1:0] : req_h_reg;
    assign req_area_next = AREA_W'(w_op) * AREA_W'(h_op);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            req_w_reg    <= '0;
            req_h_reg    <= '0;
            req_fps_reg  <= '0;
            req_area_reg <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_MODE:    mode_reg    <= pwdata[0];
                REG_REQ_W:   req_w_reg   <= pwdata[DIM_BITS-1:0];
                REG_REQ_H:   req_h_reg   <= pwdata[DIM_BITS-1:0];
                REG_REQ_FPS: req_fps_reg <= pwdata[FPS_BITS-1:0];
                default:     ;
            endcase
            req_area_reg <= req_area_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MODE:    prdata = PDATA_W'(mode_reg);
            REG_REQ_W:   prdata = PDATA_W'(req_w_reg);
            REG_REQ_H:   prdata = PDATA_W'(req_h_reg);
            REG_REQ_FPS: prdata = PDATA_W'(req_fps_reg);
            default:     prdata = '0;
        endcase
    end

    assign cfg.mode     = mode_reg;
    assign cfg.req.w    = req_w_reg;
    assign cfg.req.h    = req_h_reg;
    assign cfg.req.fps  = req_fps_reg;
    assign cfg.req_area = req_area_reg;

endmodule

`default_nettype wire

/* hdl/vfns_front.sv */
`default_nettype none

module vfns_front
    import vfns_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    vfns_in_if.sink     cap,
    input  wire cfg_t   cfg,
    input  wire         hold,
    output logic        s2_valid,
    output item_t       s2_item
);

    typedef struct packed {
        logic has_entry;
        logic is_last;
        fmt_t fmt;
    } raw_t;

    logic  s1_valid_reg;
    logic  s2_valid_reg;
    raw_t  s1_reg;
    item_t s2_reg;
    item_t s2_next;
    logic  s2_free;
    logic  in_ready;

    assign s2_free   = !s2_valid_reg || !hold;
    assign in_ready  = !s1_valid_reg || s2_free;
    assign cap.ready = in_ready;

    // area product and weighted fps distances, one register ahead of scoring
    always_comb
    begin
        s2_next.has_entry     = s1_reg.has_entry;
        s2_next.is_last       = s1_reg.is_last;
        s2_next.fmt           = s1_reg.fmt;
        s2_next.area          = AREA_W'(s1_reg.fmt.w) * AREA_W'(s1_reg.fmt.h);
        s2_next.fterm[TGT_REQ] = fps_term(s1_reg.fmt.fps, cfg.req.fps);
        s2_next.fterm[TGT_HD]  = fps_term(s1_reg.fmt.fps, FPS_BITS'(STD_FPS));
        s2_next.fterm[TGT_SD]  = fps_term(s1_reg.fmt.fps, FPS_BITS'(STD_FPS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= cap.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && cap.valid)
        begin
            s1_reg.has_entry <= cap.has_entry;
            s1_reg.is_last   <= cap.is_last;
            s1_reg.fmt.w     <= cap.cap_width;
            s1_reg.fmt.h     <= cap.cap_height;
            s1_reg.fmt.fps   <= cap.cap_fps;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_item  = s2_reg;

endmodule

`default_nettype wire

/* hdl/vfns_track.sv */
`default_nettype none

module vfns_track
    import vfns_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         fire,
    input  wire item_t  item,
    input  wire cfg_t   cfg,
    output res_t        res
);

    logic                any_seen_reg;
    logic                any_seen_next;
    logic [SCORE_W-1:0]  best_score_reg [NTGT];
    fmt_t                best_fmt_reg   [NTGT];
    fmt_t                best_fmt_next  [NTGT];
    logic [SCORE_W-1:0]  score          [NTGT];
    logic [DIFF_W-1:0]   tgt_area       [NTGT];
    logic [NTGT-1:0]     take;
    fmt_t                max_fmt_reg;
    fmt_t                max_fmt_next;
    logic [AREA_W-1:0]   max_area_reg;
    logic                take_max;
    logic                first;
    logic                seen;

    assign first = !any_seen_reg;
    assign seen  = any_seen_reg || item.has_entry;

    assign tgt_area[TGT_REQ] = DIFF_W'(cfg.req_area);
    assign tgt_area[TGT_HD]  = DIFF_W'(HD_W * HD_H);
    assign tgt_area[TGT_SD]  = DIFF_W'(SD_W * SD_H);

    // three nearest searches; strict improvement so the first of a tie stays
    always_comb
    begin
        for (int t = 0; t < NTGT; t++)
        begin
            score[t] = SCORE_W'(abs_diff(DIFF_W'(item.area), tgt_area[t]))
                     + SCORE_W'(item.fterm[t]);
            take[t]  = item.has_entry && (first || score[t] < best_score_reg[t]);
            best_fmt_next[t] = take[t] ? item.fmt : best_fmt_reg[t];
        end
    end

    // largest area, higher fps breaks an area tie
    assign take_max = item.has_entry &&
                      (first || item.area > max_area_reg ||
                       (item.area == max_area_reg && item.fmt.fps > max_fmt_reg.fps));
    assign max_fmt_next = take_max ? item.fmt : max_fmt_reg;

    always_comb
    begin
        if (!seen)
        begin
            res.fmt = cfg.req;
            res.by  = SRC_ECHO;
        end
        else if (!cfg.mode)
        begin
            res.fmt = best_fmt_next[TGT_REQ];
            res.by  = SRC_REQ;
        end
        else if (32'(best_fmt_next[TGT_HD].w) >= 32'(HD_MIN_W) &&
                 32'(best_fmt_next[TGT_HD].h) >= 32'(HD_MIN_H))
        begin
            res.fmt = best_fmt_next[TGT_HD];
            res.by  = SRC_HD;
        end
        else if (32'(best_fmt_next[TGT_SD].w) >= 32'(SD_MIN_W) &&
                 32'(best_fmt_next[TGT_SD].h) >= 32'(SD_MIN_H))
        begin
            res.fmt = best_fmt_next[TGT_SD];
            res.by  = SRC_SD;
        end
        else if (cfg.req.w != '0 && cfg.req.h != '0)
        begin
            res.fmt = best_fmt_next[TGT_REQ];
            res.by  = SRC_REQ;
        end
        else
        begin
            res.fmt = max_fmt_next;
            res.by  = SRC_MAX;
        end
    end

    // the last item closes the list; bests are overwritten by the next first entry
    assign any_seen_next = item.is_last ? 1'b0 : seen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_seen_reg <= 1'b0;
        end
        else if (fire)
        begin
            any_seen_reg <= any_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int t = 0; t < NTGT; t++)
            begin
                if (take[t])
                begin
                    best_score_reg[t] <= score[t];
                    best_fmt_reg[t]   <= item.fmt;
                end
            end
            if (take_max)
            begin
                max_fmt_reg  <= item.fmt;
                max_area_reg <= item.area;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/video_format_nearest_selector_core.sv */
`default_nettype none
// A result is offered once the last item of a list has passed the input, distance
// and result registers. Throughput: one item per cycle unless a last item is held; the
// area multiply has its own stage ahead of the scoring stage, which updates all running
// bests at once. A waiting result stalls a following last item and the items behind it.
// Reset (rst_n, asynchronous, active low) clears flags and config, empties the list.

module video_format_nearest_selector_core
    import vfns_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    // configuration port
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [PADDR_W-1:0]   paddr,
    input  wire [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // offered formats in, chosen format out
    vfns_in_if.sink             cap,
    vfns_out_if.source          sel
);

    cfg_t  cfg;
    item_t s2_item;
    logic  s2_valid;
    logic  hold;
    logic  fire;
    res_t  res;
    res_t  out_reg;
    logic  out_valid_reg;

    // register file: mode, request and the request area product
    vfns_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register, then area and fps distance stage
    vfns_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cap      (cap),
        .cfg      (cfg),
        .hold     (hold),
        .s2_valid (s2_valid),
        .s2_item  (s2_item)
    );

    // A last item can only be scored when the result register is free or
    // being emptied in the same cycle.
    assign hold = s2_valid && s2_item.is_last && out_valid_reg && !sel.ready;
    assign fire = s2_valid && !hold;

    // running bests and the decision taken at the last item
    vfns_track u_track (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (s2_item),
        .cfg   (cfg),
        .res   (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && s2_item.is_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (sel.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && s2_item.is_last)
        begin
            out_reg <= res;
        end
    end

    assign sel.valid      = out_valid_reg;
    assign sel.sel_width  = out_reg.fmt.w;
    assign sel.sel_height = out_reg.fmt.h;
    assign sel.sel_fps    = out_reg.fmt.fps;
    assign sel.chosen_by  = out_reg.by;

endmodule

`default_nettype wire
